// File: rtl/igfr_pkg.sv
// Shared types and constants of the idle-gap frame receiver.
package igfr_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int Q_DEPTH   = 4;
	localparam int QPTR_W    = $clog2(Q_DEPTH);
	localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [15:0] IDLE_TICKS_RST = 16'd20;
	localparam logic [15:0] IDLE_CNT_MAX   = 16'hFFFF;

	// Input item kinds.
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Result status codes.
	localparam logic [1:0] STS_BYTE     = 2'd0;
	localparam logic [1:0] STS_NO_FRAME = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  rx_byte;
		logic [15:0] max_len;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: rtl/igfr_front.sv
// Front end: takes commands, classifies them and hands them to the command queue.
module igfr_front import igfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] max_len,
	input  q_status_t   q_stat,
	output logic        push,
	output cmd_t        push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;
	logic known;
	op_t  op;

	always_comb begin
		known = 1'b1;
		op    = OP_BYTE;
		case (kind)
			KIND_BYTE: op = OP_BYTE;
			KIND_TICK: op = OP_TICK;
			KIND_READ: op = OP_READ;
			default:   known = 1'b0;
		endcase
	end

	assign push   = valid_s1 && !q_stat.full;
	assign busy   = valid_s1 && q_stat.full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			// Unknown kinds are dropped here and never reach the queue.
			valid_s1 <= known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op      <= op;
			cmd_s1.rx_byte <= rx_byte;
			cmd_s1.max_len <= max_len;
		end
	end

	assign push_cmd = cmd_s1;

endmodule

// File: rtl/igfr_queue.sv
// Short command queue between the front end and the frame engine.
module igfr_queue import igfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t q_stat
);

	cmd_t              entry_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == QCNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_cmd      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/igfr_back.sv
// Frame engine: frame buffer, idle timer, receive state and the read streamer.
module igfr_back import igfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] idle_ticks,
	input  q_status_t   q_stat,
	input  cmd_t        pop_cmd,
	output logic        pop,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [7:0]  data,
	output logic        last,
	output logic [6:0]  frame_length,
	output logic        overflow
);

	typedef enum logic [1:0] {
		BK_IDLE   = 2'b01,
		BK_STREAM = 2'b10
	} bk_state_t;

	typedef enum logic [2:0] {
		RX_IDLE      = 3'b001,
		RX_RECEIVING = 3'b010,
		RX_RECEIVED  = 3'b100
	} rx_state_t;

	logic [7:0]        mem [BUF_DEPTH];
	logic [7:0]        rd_data_q;

	bk_state_t         bk_state_q;
	rx_state_t         rx_state_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic [15:0]       idle_cnt_q;
	logic              ovf_flag_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [ADDR_W-1:0] rd_last_q;
	logic              strobe_q;

	logic [1:0]        status_q;
	logic              last_q;
	logic [CNT_W-1:0]  flen_q;
	logic              ovf_out_q;
	logic              data_sel_q;

	logic              buf_full;
	logic              mem_we;
	logic [15:0]       cnt_inc;
	logic [CNT_W-1:0]  rd_n;
	logic              stream_last;

	assign pop         = (bk_state_q == BK_IDLE) && !q_stat.empty;
	assign buf_full    = (byte_count_q >= CNT_W'(BUF_DEPTH));
	assign mem_we      = pop && (pop_cmd.op == OP_BYTE) && !buf_full;
	assign cnt_inc     = (idle_cnt_q < IDLE_CNT_MAX) ? idle_cnt_q + 16'd1 : idle_cnt_q;
	assign rd_n        = (pop_cmd.max_len < 16'(byte_count_q)) ?
	                     CNT_W'(pop_cmd.max_len) : byte_count_q;
	assign stream_last = (rd_ptr_q == rd_last_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[byte_count_q[ADDR_W-1:0]] <= pop_cmd.rx_byte;
		end
		rd_data_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_state_q   <= BK_IDLE;
			rx_state_q   <= RX_IDLE;
			byte_count_q <= '0;
			idle_cnt_q   <= '0;
			ovf_flag_q   <= 1'b0;
			rd_ptr_q     <= '0;
			rd_last_q    <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (bk_state_q)
				BK_IDLE: begin
					if (pop) begin
						case (pop_cmd.op)
							OP_BYTE: begin
								if (buf_full) begin
									ovf_flag_q <= 1'b1;
								end else begin
									byte_count_q <= byte_count_q + 1'b1;
								end
								rx_state_q <= RX_RECEIVING;
								idle_cnt_q <= '0;
							end
							OP_TICK: begin
								if (rx_state_q == RX_RECEIVING) begin
									if (cnt_inc >= idle_ticks) begin
										idle_cnt_q <= '0;
										rx_state_q <= RX_RECEIVED;
									end else begin
										idle_cnt_q <= cnt_inc;
									end
								end
							end
							OP_READ: begin
								if (rx_state_q == RX_RECEIVED) begin
									// The frame is emptied now; the buffer contents stay
									// intact until the stream has gone out.
									byte_count_q <= '0;
									ovf_flag_q   <= 1'b0;
									idle_cnt_q   <= '0;
									rx_state_q   <= RX_IDLE;
									if (rd_n == '0) begin
										strobe_q <= 1'b1;
									end else begin
										rd_ptr_q   <= '0;
										rd_last_q  <= ADDR_W'(rd_n - 1'b1);
										bk_state_q <= BK_STREAM;
									end
								end else begin
									strobe_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				BK_STREAM: begin
					strobe_q <= 1'b1;
					rd_ptr_q <= rd_ptr_q + 1'b1;
					if (stream_last) begin
						bk_state_q <= BK_IDLE;
					end
				end
				default: begin
					bk_state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bk_state_q == BK_STREAM) begin
			status_q   <= STS_BYTE;
			last_q     <= stream_last;
			data_sel_q <= 1'b1;
		end else if (pop && pop_cmd.op == OP_READ) begin
			status_q   <= (rx_state_q == RX_RECEIVED) ? STS_EMPTY : STS_NO_FRAME;
			last_q     <= 1'b1;
			data_sel_q <= 1'b0;
			flen_q     <= byte_count_q;
			ovf_out_q  <= ovf_flag_q;
		end
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign data         = data_sel_q ? rd_data_q : 8'd0;
	assign last         = last_q;
	assign frame_length = 7'(flen_q);
	assign overflow     = ovf_out_q;

endmodule

// File: rtl/idle_gap_frame_receiver.sv
// Top level of the idle-gap frame receiver.
//
// Commands enter on start/kind/rx_byte/max_len and are taken at a clock edge where start
// is high and busy is low. A received byte appends to the 64-byte frame buffer, a timer
// tick advances the idle counter while a frame is being received, and a read request streams the frame out.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes idle_ticks; cfg_ready
// is always high, and writes belong in periods with no command in flight.
// Each command passes an input register and a four-entry queue before the frame engine
// takes it. Bytes, ticks and reads that yield one result do not hold the engine; such a
// result appears in the cycle after the engine takes the read.
// A read of n bytes holds the engine in its streaming state until it has read the last
// byte, as the buffer memory delivers one byte a cycle through its registered read port.
// The engine first enters its streaming state; the bytes then follow one per cycle, each
// valid while strobe is high; the receiver cannot stall them, and the last result of a
// read carries last.
// busy is high while a command waits in the input register and the queue is full; the
// queue fills only while a read is streaming.
// Reset clears the queue, the receive state, the counters and sets idle_ticks to 20;
// the buffer contents are not cleared.
module idle_gap_frame_receiver import igfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] max_len,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [7:0]  data,
	output logic        last,
	output logic [6:0]  frame_length,
	output logic        overflow
);

	logic [15:0] idle_ticks_q;
	logic        push;
	cmd_t        push_cmd;
	logic        pop;
	cmd_t        pop_cmd;
	q_status_t   q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= IDLE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			idle_ticks_q <= cfg_data;
		end
	end

	igfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.max_len  (max_len),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	igfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_stat   (q_stat)
	);

	igfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.idle_ticks   (idle_ticks_q),
		.q_stat       (q_stat),
		.pop_cmd      (pop_cmd),
		.pop          (pop),
		.strobe       (strobe),
		.status       (status),
		.data         (data),
		.last         (last),
		.frame_length (frame_length),
		.overflow     (overflow)
	);

`ifndef SYNTHESIS
	// A result that carries no frame byte is always the only result of its read.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != STS_BYTE) |-> last)
		else $error("non-byte result without last");

	// A frame stream runs without gaps until its last byte.
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == STS_BYTE && !last) |=> (strobe && status == STS_BYTE))
		else $error("frame stream interrupted");

	// The queue never reports full and empty together.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// Nothing is popped from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");
`endif

endmodule
